// File: hdl/crcfpp_pkg.sv
// Shared types, codes and the byte-wide CRC-32 step for the framed packet parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package crcfpp_pkg;

	localparam int CHECKSUM_BYTES  = 4;
	localparam int MAX_FIELD_BYTES = 8;

	// Parser phase codes
	localparam logic [2:0] PH_HUNT     = 3'd0;
	localparam logic [2:0] PH_SIZE     = 3'd1;
	localparam logic [2:0] PH_DATA     = 3'd2;
	localparam logic [2:0] PH_CSUM     = 3'd3;
	localparam logic [2:0] PH_END_BAD  = 3'd4;
	localparam logic [2:0] PH_END_GOOD = 3'd5;

	// Outcome codes
	localparam logic [1:0] OUT_NONE = 2'd0;
	localparam logic [1:0] OUT_GOOD = 2'd1;
	localparam logic [1:0] OUT_BAD  = 2'd2;
	localparam logic [1:0] OUT_ERR  = 2'd3;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_MAGIC_VALUE = 3'd0;
	localparam logic [2:0] REG_MAGIC_BYTES = 3'd1;
	localparam logic [2:0] REG_SIZE_BYTES  = 3'd2;
	localparam logic [2:0] REG_MAX_PACKET  = 3'd3;

	// Reflected CRC-32 polynomial
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// Configuration as seen by the parsing logic
	typedef struct packed {
		logic [63:0] magic_value;
		logic [3:0]  magic_len;   // header length clamped to 1..8
		logic [3:0]  size_bytes;
		logic [31:0] max_bytes;
		logic [4:0]  overhead;    // header + length field + checksum
	} cfg_t;

	// Per-item result and state view from the parser core
	typedef struct packed {
		logic [1:0]  outcome;
		logic [31:0] skip_next;
		logic [31:0] skip_now;
	} res_t;

	// One byte through a zlib-form CRC-32 (value kept post-inverted)
	function automatic logic [31:0] crc_add(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = ~crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return ~c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/crc_framed_packet_parser.sv
// Top level of the CRC-framed packet parser: input register, parser core,
// result register and configuration port. Depends on crcfpp_pkg, crcfpp_cfg, crcfpp_core.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_stall  | data_byte[7:0], restart
//  out     | out_valid / out_stall| outcome[1:0], skipped_count[31:0]
//  cfg     | cfg_valid / cfg_ready| cfg_index[2:0], cfg_data[63:0]
//
// One byte per cycle sustained while out_stall is low; an item taken goes from the input
// register through the core into the result register, the core update being one pass.
// Reset restores the register defaults and puts the parser in header hunt.
// A stalled result holds in the result register while one more item waits in the
// input register; in_stall rises only when both are full.
`default_nettype none

module crc_framed_packet_parser
	import crcfpp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        restart,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       outcome,
	output logic [31:0]      skipped_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        restart_s1;
	logic        valid_s2;
	logic [1:0]  outcome_s2;
	logic [31:0] skip_s2;
	logic        advance;
	logic        in_take;
	cfg_t        cfg;
	res_t        res;

	assign cfg_ready = 1'b1;

	crcfpp_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: item moves to the result register when that is free or being taken
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	crcfpp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (data_s1),
		.restart   (restart_s1),
		.cfg       (cfg),
		.res       (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_take || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			outcome_s2 <= res.outcome;
			skip_s2    <= res.skip_next;
		end
	end

	assign out_valid     = valid_s2;
	assign outcome       = outcome_s2;
	assign skipped_count = skip_s2;

	// A restart item reports nothing finished and a zero count
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && restart_s1) |=> (outcome == OUT_NONE) && (skipped_count == 32'd0))
		else $error("restart item did not clear outcome and count");

	// Without restart the skip count never goes down
	a_skip_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !restart_s1) |-> (res.skip_next >= res.skip_now))
		else $error("skip count decreased without restart");

	// A good packet never counts a skip
	a_good_no_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (res.outcome == OUT_GOOD)) |-> (res.skip_next == res.skip_now))
		else $error("good packet changed skip count");

endmodule

`default_nettype wire

// File: hdl/crcfpp_cfg.sv
// Configuration registers of the framed packet parser and derived lengths.
// Depends on crcfpp_pkg.
`default_nettype none

module crcfpp_cfg
	import crcfpp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  wr_index,
	input  wire logic [63:0] wr_data,
	output cfg_t             cfg
);

	logic [63:0] magic_value_q;
	logic [3:0]  magic_bytes_q;
	logic [3:0]  size_bytes_q;
	logic [31:0] max_bytes_q;
	logic [3:0]  magic_len;

	// Register writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_value_q <= 64'd0;
			magic_bytes_q <= 4'd1;
			size_bytes_q  <= 4'd2;
			max_bytes_q   <= 32'd65535;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAGIC_VALUE: magic_value_q <= wr_data;
				REG_MAGIC_BYTES: magic_bytes_q <= wr_data[3:0];
				REG_SIZE_BYTES:  size_bytes_q  <= wr_data[3:0];
				REG_MAX_PACKET:  max_bytes_q   <= wr_data[31:0];
				default: ;
			endcase
		end
	end

	// Header length: zero acts as one, above eight acts as eight
	always_comb begin
		if (magic_bytes_q == 4'd0) begin
			magic_len = 4'd1;
		end else if (magic_bytes_q > 4'(MAX_FIELD_BYTES)) begin
			magic_len = 4'(MAX_FIELD_BYTES);
		end else begin
			magic_len = magic_bytes_q;
		end
	end

	assign cfg.magic_value = magic_value_q;
	assign cfg.magic_len   = magic_len;
	assign cfg.size_bytes  = size_bytes_q;
	assign cfg.max_bytes   = max_bytes_q;
	assign cfg.overhead    = 5'(magic_len) + 5'(size_bytes_q) + 5'(CHECKSUM_BYTES);

endmodule

`default_nettype wire

// File: hdl/crcfpp_core.sv
// Parser state and the per-byte next-state logic: header hunt, length field,
// data skip, CRC-32 and checksum compare. Depends on crcfpp_pkg.
`default_nettype none

module crcfpp_core
	import crcfpp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       restart,
	input  wire cfg_t       cfg,
	output res_t            res
);

	logic [2:0]  phase_q,  phase_d;
	logic [31:0] fill_q,   fill_d;
	logic [63:0] buf_q,    buf_d;
	logic [31:0] pkt_len_q, pkt_len_d;
	logic [31:0] crc_q,    crc_d;
	logic [31:0] skip_q,   skip_d;
	logic [1:0]  outcome;

	logic [2:0]  pos;
	logic [31:0] fill_inc;
	logic [31:0] skip_inc;
	logic [63:0] buf_put;
	logic [7:0]  magic_byte;
	logic [31:0] crc_upd;
	logic [63:0] len64;
	logic        len_ok;
	logic        data_done;

	// Shared datapath pieces
	assign pos        = fill_q[2:0];
	assign fill_inc   = fill_q + 32'd1;
	assign skip_inc   = (skip_q == '1) ? skip_q : skip_q + 32'd1;
	assign magic_byte = cfg.magic_value[{pos, 3'b000} +: 8];
	assign crc_upd    = crc_add(((phase_q == PH_HUNT) && (fill_q == 32'd0)) ? 32'd0 : crc_q,
		data_byte);

	always_comb begin
		for (int i = 0; i < MAX_FIELD_BYTES; i++) begin
			buf_put[8*i +: 8] = (pos == 3'(i)) ? data_byte : buf_q[8*i +: 8];
		end
	end

	// Length field, little endian, masked to its width
	always_comb begin
		len_ok = 1'b1;
		unique case (cfg.size_bytes)
			4'd1: len64 = {56'd0, buf_put[7:0]};
			4'd2: len64 = {48'd0, buf_put[15:0]};
			4'd4: len64 = {32'd0, buf_put[31:0]};
			4'd8: len64 = buf_put;
			default: begin
				len64  = 64'd0;
				len_ok = 1'b0;
			end
		endcase
	end

	// Data count reaches packet length minus overhead
	assign data_done = (pkt_len_q <= 32'(cfg.overhead)) ||
		((33'(fill_inc) + 33'(cfg.overhead)) >= 33'(pkt_len_q));

	// Next state per byte
	always_comb begin
		phase_d   = phase_q;
		fill_d    = fill_q;
		buf_d     = buf_q;
		pkt_len_d = pkt_len_q;
		crc_d     = crc_q;
		skip_d    = skip_q;
		outcome   = OUT_NONE;
		if (restart) begin
			phase_d   = PH_HUNT;
			fill_d    = 32'd0;
			buf_d     = 64'd0;
			pkt_len_d = 32'd0;
			crc_d     = 32'd0;
			skip_d    = 32'd0;
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					if (data_byte != magic_byte) begin
						skip_d = skip_inc;
						fill_d = 32'd0;
						outcome = (fill_q == 32'd0) ? OUT_NONE : OUT_BAD;
					end else begin
						crc_d = crc_upd;
						buf_d = buf_put;
						if (fill_inc >= 32'(cfg.magic_len)) begin
							phase_d = PH_SIZE;
							fill_d  = 32'd0;
						end else begin
							fill_d = fill_inc;
						end
					end
				end
				PH_SIZE: begin
					buf_d = buf_put;
					crc_d = crc_upd;
					if ((fill_inc < 32'(cfg.size_bytes)) &&
						(fill_inc < 32'(MAX_FIELD_BYTES))) begin
						fill_d = fill_inc;
					end else begin
						fill_d = 32'd0;
						if (!len_ok) begin
							phase_d = PH_HUNT;
							outcome = OUT_ERR;
						end else begin
							pkt_len_d = len64[31:0];
							if ((len64 > {32'd0, cfg.max_bytes}) ||
								(len64 < 64'(cfg.overhead))) begin
								skip_d  = skip_inc;
								phase_d = PH_END_BAD;
								outcome = OUT_BAD;
							end else if (len64 > 64'(cfg.overhead)) begin
								phase_d = PH_DATA;
							end else begin
								phase_d = PH_CSUM;
							end
						end
					end
				end
				PH_DATA: begin
					crc_d = crc_upd;
					if (data_done) begin
						fill_d  = 32'd0;
						phase_d = PH_CSUM;
					end else begin
						fill_d = fill_inc;
					end
				end
				PH_CSUM: begin
					buf_d = buf_put;
					if (fill_inc < 32'(CHECKSUM_BYTES)) begin
						fill_d = fill_inc;
					end else begin
						fill_d = 32'd0;
						if (buf_put[31:0] == crc_q) begin
							phase_d = PH_END_GOOD;
							outcome = OUT_GOOD;
						end else begin
							skip_d  = skip_inc;
							phase_d = PH_END_BAD;
							outcome = OUT_BAD;
						end
					end
				end
				// End phases and unused codes: report error, hold state
				default: outcome = OUT_ERR;
			endcase
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			fill_q    <= 32'd0;
			buf_q     <= 64'd0;
			pkt_len_q <= 32'd0;
			crc_q     <= 32'd0;
			skip_q    <= 32'd0;
		end else if (step) begin
			phase_q   <= phase_d;
			fill_q    <= fill_d;
			buf_q     <= buf_d;
			pkt_len_q <= pkt_len_d;
			crc_q     <= crc_d;
			skip_q    <= skip_d;
		end
	end

	assign res.outcome   = outcome;
	assign res.skip_next = skip_d;
	assign res.skip_now  = skip_q;

endmodule

`default_nettype wire

// File: dv/crc_framed_packet_parser_test.sv
// Self-checking bench for crc_framed_packet_parser: streams framed packets, noise and
// restarts through the byte channel under several register settings. A scoreboard class
// predicts every result. Depends on crcfpp_pkg and the block's RTL.

module crc_framed_packet_parser_test;
	import crcfpp_pkg::*;

	localparam int ITEMS_TARGET = 1400;
	localparam int MAX_REPORTS  = 10;
	localparam logic [2:0] REG_UNUSED = 3'd4;

	typedef enum {LEN_EXACT, LEN_SHORT, LEN_LONG, LEN_WILD} len_mode_t;
	typedef enum {STALL_NEVER, STALL_SOME, STALL_HEAVY} stall_mode_t;

	typedef struct {
		logic [1:0]  outcome;
		logic [31:0] skipped;
	} deframe_result_t;

	// Deframer prediction and result checking
	class deframe_scoreboard;
		logic [63:0] magic_val;
		logic [3:0]  magic_n;
		logic [3:0]  size_n;
		logic [31:0] max_len;
		logic [2:0]  phase;
		int unsigned fill;
		logic [63:0] field_buf;
		logic [63:0] pkt_len;
		logic [31:0] crc;
		logic [31:0] skips;
		deframe_result_t expected_results[$];
		int errors;
		int checked;
		int seen[4];

		function new();
			magic_val = '0;
			magic_n   = 4'd1;
			size_n    = 4'd2;
			max_len   = 32'd65535;
			back_to_hunt();
			errors  = 0;
			checked = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void back_to_hunt();
			phase     = PH_HUNT;
			fill      = 0;
			field_buf = '0;
			pkt_len   = '0;
			crc       = '0;
			skips     = '0;
		endfunction

		// zlib-form CRC-32: value held inverted between bytes
		static function logic [31:0] crc_step(input logic [31:0] crc_in, input logic [7:0] b);
			logic [31:0] r;
			r = ~crc_in;
			r[7:0] = r[7:0] ^ b;
			for (int k = 0; k < 8; k++)
				r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
			return ~r;
		endfunction

		function logic [63:0] header_len();
			if (magic_n == 4'd0)
				return 64'd1;
			if (magic_n > MAX_FIELD_BYTES)
				return 64'd8;
			return {60'd0, magic_n};
		endfunction

		function logic [63:0] overhead();
			return header_len() + size_n + CHECKSUM_BYTES;
		endfunction

		function void bump_skips();
			if (skips != '1)
				skips++;
		endfunction

		function void load_byte(input logic [7:0] b);
			field_buf[8 * (fill % 8) +: 8] = b;
			fill++;
		endfunction

		function logic [1:0] predict_byte(input logic [7:0] b);
			logic [63:0] oh;
			logic [63:0] dsize;
			case (phase)
				PH_HUNT: begin
					if (fill >= MAX_FIELD_BYTES)
						fill = 0;
					if (b != magic_val[8 * fill +: 8]) begin
						bump_skips();
						if (fill == 0)
							return OUT_NONE;
						fill = 0;
						return OUT_BAD;
					end
					if (fill == 0)
						crc = '0;
					crc = crc_step(crc, b);
					load_byte(b);
					if (fill >= header_len()) begin
						phase = PH_SIZE;
						fill  = 0;
					end
					return OUT_NONE;
				end
				PH_SIZE: begin
					load_byte(b);
					crc = crc_step(crc, b);
					if (fill < size_n && fill < MAX_FIELD_BYTES)
						return OUT_NONE;
					fill = 0;
					case (size_n)
						4'd1: pkt_len = {56'd0, field_buf[7:0]};
						4'd2: pkt_len = {48'd0, field_buf[15:0]};
						4'd4: pkt_len = {32'd0, field_buf[31:0]};
						4'd8: pkt_len = field_buf;
						default: begin
							phase = PH_HUNT;
							return OUT_ERR;
						end
					endcase
					oh = overhead();
					if (pkt_len > {32'd0, max_len} || pkt_len < oh) begin
						bump_skips();
						phase = PH_END_BAD;
						return OUT_BAD;
					end
					phase = (pkt_len > oh) ? PH_DATA : PH_CSUM;
					return OUT_NONE;
				end
				PH_DATA: begin
					crc = crc_step(crc, b);
					fill++;
					// data size follows the registers as they are now
					oh    = overhead();
					dsize = (pkt_len > oh) ? pkt_len - oh : 64'd0;
					if (fill >= dsize) begin
						fill  = 0;
						phase = PH_CSUM;
					end
					return OUT_NONE;
				end
				PH_CSUM: begin
					load_byte(b);
					if (fill < CHECKSUM_BYTES)
						return OUT_NONE;
					fill = 0;
					if (field_buf[31:0] == crc) begin
						phase = PH_END_GOOD;
						return OUT_GOOD;
					end
					bump_skips();
					phase = PH_END_BAD;
					return OUT_BAD;
				end
				default: return OUT_ERR;
			endcase
		endfunction

		function void write_reg(input logic [2:0] idx, input logic [63:0] d);
			case (idx)
				REG_MAGIC_VALUE: magic_val = d;
				REG_MAGIC_BYTES: magic_n   = d[3:0];
				REG_SIZE_BYTES:  size_n    = d[3:0];
				REG_MAX_PACKET:  max_len   = d[31:0];
				default: ;
			endcase
		endfunction

		function void note_item(input logic [7:0] b, input logic r);
			deframe_result_t e;
			if (r) begin
				back_to_hunt();
				e.outcome = OUT_NONE;
			end else begin
				e.outcome = predict_byte(b);
			end
			e.skipped = skips;
			expected_results.push_back(e);
		endfunction

		function void report(input string what, input logic [63:0] want, input logic [63:0] got);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch on %s at result %0d: expected %0h, got %0h",
					what, checked, want, got);
		endfunction

		function void check_result(input logic [1:0] oc, input logic [31:0] sk);
			deframe_result_t e;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: outcome %0d skipped %0d", oc, sk);
				return;
			end
			e = expected_results.pop_front();
			checked++;
			if (!$isunknown(oc))
				seen[oc]++;
			if (oc !== e.outcome)
				report("outcome", e.outcome, oc);
			if (sk !== e.skipped)
				report("skipped_count", e.skipped, sk);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'd0;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  outcome;
	logic [31:0] skipped_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [63:0] cfg_data = 64'd0;

	deframe_scoreboard sb;
	int items_sent = 0;
	int burst_left = 0;
	int packets_sent = 0;
	int cfg_writes = 0;
	int cfg_phases = 0;
	stall_mode_t stall_mode = STALL_NEVER;
	int mode_left = 0;

	crc_framed_packet_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.outcome(outcome),
		.skipped_count(skipped_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: check accepted items, stall in modes of varying weight
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				sb.check_result(outcome, skipped_count);
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 2));
				mode_left  = $urandom_range(50, 400);
			end
			mode_left--;
			case (stall_mode)
				STALL_NEVER: out_stall <= 1'b0;
				STALL_SOME:  out_stall <= ($urandom_range(0, 3) == 0);
				default:     out_stall <= ($urandom_range(0, 9) < 8);
			endcase
		end
	end

	// Send one item; bursts of random length separated by idle gaps
	task automatic push_item(input logic [7:0] b, input logic r);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		restart   <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(b, r);
		items_sent++;
		burst_left--;
	endtask

	// Hold the sender until every predicted result has been seen
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
		cfg_writes++;
	endtask

	task automatic cfg_done();
		cfg_valid <= 1'b0;
	endtask

	// Random upper bits above the register width, half of the time
	function automatic logic [63:0] with_junk(input logic [63:0] v, input int keep);
		if ($urandom_range(0, 1) == 0)
			return v;
		return ({$urandom, $urandom} << keep) | v;
	endfunction

	task automatic apply_config(input logic [63:0] mv, input logic [3:0] mn,
		input logic [3:0] sn, input logic [31:0] ml);
		drain_results();
		cfg_write(REG_MAGIC_VALUE, mv);
		cfg_write(REG_MAGIC_BYTES, with_junk(mn, 4));
		cfg_write(REG_SIZE_BYTES, with_junk(sn, 4));
		cfg_write(REG_MAX_PACKET, with_junk(ml, 32));
		cfg_done();
		cfg_phases++;
	endtask

	// Random bytes, some drawn from the header pattern, with the odd restart
	task automatic send_noise(input int n);
		logic [7:0] b;
		int pos;
		repeat (n) begin
			pos = $urandom_range(0, 7);
			b = ($urandom_range(0, 3) == 0) ? sb.magic_val[8 * pos +: 8]
				: 8'($urandom_range(0, 255));
			push_item(b, $urandom_range(0, 19) == 0);
		end
	endtask

	// Frame one packet for the current registers; optionally change a register
	// before byte split_at while the parser sits mid-packet
	task automatic send_packet(input int data_n, input len_mode_t mode, input bit bad_crc,
		input int split_at);
		logic [7:0]  bytes[$];
		logic [63:0] total;
		logic [63:0] hl;
		logic [63:0] len_val;
		logic [31:0] c;
		int lb;
		hl = sb.header_len();
		lb = (sb.size_n == 4'd0) ? 1 : (sb.size_n > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES
			: int'(sb.size_n);
		total = hl + sb.size_n + CHECKSUM_BYTES + data_n;
		case (mode)
			LEN_SHORT: len_val = $urandom_range(0, int'(total) - data_n - 1);
			LEN_LONG:  len_val = {32'd0, sb.max_len} + 64'd1 + $urandom_range(0, 1000);
			LEN_WILD:  len_val = {$urandom, $urandom};
			default:   len_val = total;
		endcase
		for (int i = 0; i < hl; i++)
			bytes.push_back(sb.magic_val[8 * i +: 8]);
		for (int i = 0; i < lb; i++)
			bytes.push_back(len_val[8 * i +: 8]);
		repeat (data_n)
			bytes.push_back(8'($urandom_range(0, 255)));
		c = '0;
		foreach (bytes[i])
			c = deframe_scoreboard::crc_step(c, bytes[i]);
		if (bad_crc)
			c = c ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < CHECKSUM_BYTES; i++)
			bytes.push_back(c[8 * i +: 8]);
		foreach (bytes[i]) begin
			if (i == split_at) begin
				drain_results();
				if ($urandom_range(0, 1) == 0)
					cfg_write(REG_MAGIC_BYTES, 64'($urandom_range(0, 15)));
				else
					cfg_write(REG_MAX_PACKET, 64'($urandom));
				cfg_done();
			end
			push_item(bytes[i], 1'b0);
		end
		packets_sent++;
	endtask

	// Part of the header, then a byte that breaks the match
	task automatic send_broken_header();
		int hl;
		int k;
		hl = int'(sb.header_len());
		k = (hl > 1) ? $urandom_range(1, hl - 1) : 0;
		for (int i = 0; i < k; i++)
			push_item(sb.magic_val[8 * i +: 8], 1'b0);
		push_item(sb.magic_val[8 * k +: 8] ^ 8'($urandom_range(1, 255)), 1'b0);
	endtask

	function automatic int pick_data_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(21, 200) : $urandom_range(0, 20);
	endfunction

	initial begin
		logic [63:0] mv;
		logic [3:0]  mn;
		logic [3:0]  sn;
		logic [31:0] ml;
		int sel;
		int phase_end;
		int phase_no;

		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset registers, empty packet, then a byte past the end
		push_item(8'hFF, 1'b1);
		push_item(8'hFF, 1'b0);
		send_packet(0, LEN_EXACT, 1'b0, -1);
		push_item(8'h00, 1'b0);
		// two-byte header: broken match, bad checksum, short length, mid-packet change
		apply_config(64'hFFFF_FFFF_FFFF_C3A5, 4'd2, 4'd1, 32'hFFFF_FFFF);
		push_item(8'h00, 1'b1);
		push_item(8'hA5, 1'b0);
		push_item(8'h00, 1'b0);
		send_packet(1, LEN_EXACT, 1'b1, -1);
		push_item(8'h5A, 1'b1);
		send_packet(0, LEN_SHORT, 1'b0, -1);
		push_item(8'h00, 1'b1);
		send_packet(3, LEN_EXACT, 1'b0, 4);
		// unsupported length width, and a write to an index with no register
		apply_config(64'h0000_0000_0000_C3A5, 4'd2, 4'd3, 32'd0);
		drain_results();
		cfg_write(REG_UNUSED + 3'($urandom_range(0, 3)), {$urandom, $urandom});
		cfg_done();
		push_item(8'h00, 1'b1);
		send_packet(0, LEN_EXACT, 1'b0, -1);

		// Random: mostly framed packets under a run of register settings
		phase_no = 0;
		while (items_sent < ITEMS_TARGET) begin
			mv = {$urandom, $urandom};
			mn = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 15));
			case ($urandom_range(0, 4))
				0: sn = 4'($urandom_range(0, 15));
				1: sn = 4'd1;
				2: sn = 4'd2;
				3: sn = 4'd4;
				default: sn = 4'd8;
			endcase
			case ($urandom_range(0, 3))
				0: ml = '1;
				1: ml = $urandom_range(30, 65535);
				2: ml = $urandom_range(0, 40);
				default: ml = $urandom;
			endcase
			if ($urandom_range(0, 4) == 0)
				mv = {8{mv[7:0]}};
			case (phase_no)
				0: begin mv = '1; mn = 4'd0; sn = 4'd8; ml = '1; end
				1: begin mn = 4'd15; sn = 4'd1; ml = '0; end
				2: begin mv = '0; mn = 4'd8; sn = 4'd4; ml = 32'd40; end
				3: begin sn = 4'd0; end
				4: begin sn = 4'd15; ml = '1; end
				default: ;
			endcase
			apply_config(mv, mn, sn, ml);
			phase_no++;
			phase_end = items_sent + $urandom_range(100, 180);
			// keep the total close to the item target
			if (phase_end > ITEMS_TARGET)
				phase_end = ITEMS_TARGET;
			while (items_sent < phase_end) begin
				sel = $urandom_range(0, 99);
				if ($urandom_range(0, 6) != 0)
					push_item(8'($urandom_range(0, 255)), 1'b1);
				if (sel < 65) begin
					if ($urandom_range(0, 3) == 0)
						send_noise($urandom_range(1, 3));
					send_packet(pick_data_len(), LEN_EXACT, $urandom_range(0, 6) == 0,
						($urandom_range(0, 19) == 0) ? $urandom_range(10, 14) : -1);
					send_noise($urandom_range(0, 2));
				end else if (sel < 77) begin
					send_packet(pick_data_len(), len_mode_t'($urandom_range(1, 3)), 1'b0, -1);
				end else if (sel < 88) begin
					send_broken_header();
				end else begin
					send_noise($urandom_range(1, 12));
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d items, %0d packets framed, %0d register settings, %0d writes",
			items_sent, packets_sent, cfg_phases, cfg_writes);
		$display("outcomes seen: %0d none, %0d good, %0d bad, %0d error; %0d mismatches",
			sb.seen[OUT_NONE], sb.seen[OUT_GOOD], sb.seen[OUT_BAD], sb.seen[OUT_ERR], sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
